// ===== hdl/skct_pkg.sv =====
`default_nettype none

package skct_pkg;

    localparam int KEY_W     = 16;
    localparam int CNT_W     = 16;
    localparam int USED_W    = 7;
    localparam int STAT_W    = 2;
    localparam int DEF_DEPTH = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_CONSUME = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT       = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RESOLVE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_RM_RD,
        S_RM_WR,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/sorted_keyed_count_table_unit.sv =====
`default_nettype none

// Sorted key/count table. Entries (16-bit key, 16-bit count) live in one
// single-port-write, single-port-read memory in ascending key order, and a
// fill count marks how many are in use, so nothing is cleared after reset.
// A store adds to the matching entry (saturating at the count maximum) or,
// when the table has room and the amount is nonzero, inserts a new entry in
// order; a consume takes min(count, amount) and removes the entry when its
// count drops to zero. A small sequencer walks the memory one entry at a
// time (read, then check or move): it scans up to the key or its insertion
// point, then moves entries for an insert or a removal. Input ready is high
// only while the sequencer is idle; the result sits in an output register,
// so the next item can be taken while it waits, and that item stalls in its
// output state until the output register is free.
module sorted_keyed_count_table_unit #(
    parameter int DEPTH = skct_pkg::DEF_DEPTH
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // input channel
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire                         i_cmd,
    input  wire  [skct_pkg::KEY_W-1:0]  i_key,
    input  wire  [skct_pkg::CNT_W-1:0]  i_amount,
    // result channel
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [skct_pkg::CNT_W-1:0]  o_taken,
    output logic [skct_pkg::CNT_W-1:0]  o_remaining,
    output logic [skct_pkg::USED_W-1:0] o_entries_used,
    output logic [skct_pkg::STAT_W-1:0] o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = skct_pkg::KEY_W;
    localparam int NW = skct_pkg::CNT_W;

    // entry memory, no reset: only entries below the fill count are used
    skct_pkg::t_entry r_mem [DEPTH];
    skct_pkg::t_entry r_rd;

    skct_pkg::t_state r_state, n_state;

    // latched item
    logic          r_cmd;
    logic [KW-1:0] r_key;
    logic [NW-1:0] r_amt;

    // sequencer datapath
    logic [AW-1:0] r_idx, n_idx;     // scan / move pointer
    logic [AW-1:0] r_pos, n_pos;     // match or insertion point
    logic          r_found, n_found;
    logic [NW-1:0] r_have, n_have;
    logic [CW-1:0] r_occ, n_occ;     // fill count

    // pending result
    logic [NW-1:0]                 r_taken, n_taken;
    logic [NW-1:0]                 r_rem, n_rem;
    logic [skct_pkg::STAT_W-1:0]   r_stat, n_stat;

    // output register
    logic                          r_o_valid, n_o_valid;
    logic [NW-1:0]                 r_o_taken, n_o_taken;
    logic [NW-1:0]                 r_o_rem, n_o_rem;
    logic [skct_pkg::USED_W-1:0]   r_o_used, n_o_used;
    logic [skct_pkg::STAT_W-1:0]   r_o_stat, n_o_stat;

    // memory controls
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic [AW-1:0]           w_raddr;
    skct_pkg::t_entry        w_wdata;

    logic w_in_xfer;
    logic w_out_free;

    // shared compare / add unit
    logic              w_key_eq;
    logic              w_key_gt;
    logic              w_scan_last;
    logic [NW:0]       w_sum;
    logic              w_sat;
    logic [NW-1:0]     w_min;
    logic [NW-1:0]     w_left;
    logic              w_ins_at_end;
    logic              w_rm_last;
    logic              w_rm_done;
    logic              w_ins_done;
    logic [AW-1:0]     w_idx_dn;
    logic [AW-1:0]     w_idx_up;

    assign o_ready    = (r_state == skct_pkg::S_IDLE);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;

    assign w_key_eq    = (r_rd.key == r_key);
    assign w_key_gt    = (r_rd.key > r_key);
    assign w_scan_last = ((CW+1)'(r_idx) + (CW+1)'(1)) == (CW+1)'(r_occ);

    assign w_sum  = (NW+1)'(r_have) + (NW+1)'(r_amt);
    assign w_sat  = w_sum[NW];
    assign w_min  = (r_have < r_amt) ? r_have : r_amt;
    assign w_left = r_have - w_min;

    assign w_ins_at_end = (CW'(r_pos) == r_occ);
    // removal with nothing above the removed entry
    assign w_rm_last    = ((CW+1)'(r_pos) + (CW+1)'(1)) == (CW+1)'(r_occ);
    // last move of a removal: the entry just written was the top one minus one
    assign w_rm_done    = ((CW+1)'(r_idx) + (CW+1)'(2)) == (CW+1)'(r_occ);

    assign w_idx_dn   = r_idx - AW'(1);
    assign w_idx_up   = r_idx + AW'(1);
    assign w_ins_done = (w_idx_dn == r_pos);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            skct_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (r_occ == '0) ? skct_pkg::S_RESOLVE : skct_pkg::S_SCAN_RD;
                end
            end
            skct_pkg::S_SCAN_RD: begin
                n_state = skct_pkg::S_SCAN_CHK;
            end
            skct_pkg::S_SCAN_CHK: begin
                if (w_key_eq || w_key_gt || w_scan_last) begin
                    n_state = skct_pkg::S_RESOLVE;
                end else begin
                    n_state = skct_pkg::S_SCAN_RD;
                end
            end
            skct_pkg::S_RESOLVE: begin
                n_state = skct_pkg::S_OUT;
                if (r_cmd == skct_pkg::CMD_STORE) begin
                    if (!r_found && (r_occ != CW'(DEPTH)) && (r_amt != '0)
                        && !w_ins_at_end) begin
                        n_state = skct_pkg::S_INS_RD;
                    end
                end else if (r_found && (w_left == '0) && !w_rm_last) begin
                    n_state = skct_pkg::S_RM_RD;
                end
            end
            skct_pkg::S_INS_RD: begin
                n_state = skct_pkg::S_INS_WR;
            end
            skct_pkg::S_INS_WR: begin
                n_state = w_ins_done ? skct_pkg::S_INS_PUT : skct_pkg::S_INS_RD;
            end
            skct_pkg::S_INS_PUT: begin
                n_state = skct_pkg::S_OUT;
            end
            skct_pkg::S_RM_RD: begin
                n_state = skct_pkg::S_RM_WR;
            end
            skct_pkg::S_RM_WR: begin
                n_state = w_rm_done ? skct_pkg::S_OUT : skct_pkg::S_RM_RD;
            end
            skct_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = skct_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skct_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_found   = r_found;
        n_have    = r_have;
        n_occ     = r_occ;
        n_taken   = r_taken;
        n_rem     = r_rem;
        n_stat    = r_stat;
        n_o_valid = r_o_valid;
        n_o_taken = r_o_taken;
        n_o_rem   = r_o_rem;
        n_o_used  = r_o_used;
        n_o_stat  = r_o_stat;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_raddr   = r_idx;
        w_wdata   = '{key: r_key, count: r_amt};

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            skct_pkg::S_IDLE: begin
                n_idx   = '0;
                n_pos   = '0;
                n_found = 1'b0;
                n_have  = '0;
            end
            skct_pkg::S_SCAN_RD: begin
                w_raddr = r_idx;
            end
            skct_pkg::S_SCAN_CHK: begin
                if (w_key_eq) begin
                    n_found = 1'b1;
                    n_pos   = r_idx;
                    n_have  = r_rd.count;
                end else if (w_key_gt) begin
                    n_pos   = r_idx;
                end else if (w_scan_last) begin
                    // past the top entry; unused when the table is full
                    n_pos   = AW'(r_occ);
                end else begin
                    n_idx   = w_idx_up;
                end
            end
            skct_pkg::S_RESOLVE: begin
                n_taken = '0;
                n_rem   = '0;
                n_stat  = skct_pkg::ST_OK;
                if (r_cmd == skct_pkg::CMD_STORE) begin
                    if (r_found) begin
                        w_we    = 1'b1;
                        w_wdata = '{key: r_key,
                                    count: w_sat ? skct_pkg::CNT_MAX : w_sum[NW-1:0]};
                        n_rem   = w_sat ? skct_pkg::CNT_MAX : w_sum[NW-1:0];
                        n_stat  = w_sat ? skct_pkg::ST_SAT : skct_pkg::ST_OK;
                    end else if (r_occ == CW'(DEPTH)) begin
                        n_stat  = skct_pkg::ST_FULL;
                    end else if (r_amt != '0) begin
                        n_rem   = r_amt;
                        if (w_ins_at_end) begin
                            w_we  = 1'b1;
                            n_occ = r_occ + CW'(1);
                        end else begin
                            // move entries up from the top down to the slot
                            n_idx = AW'(r_occ);
                        end
                    end
                end else begin
                    if (!r_found) begin
                        n_stat = skct_pkg::ST_NOT_FOUND;
                    end else begin
                        n_taken = w_min;
                        n_rem   = w_left;
                        if (w_left != '0) begin
                            w_we    = 1'b1;
                            w_wdata = '{key: r_key, count: w_left};
                        end else if (w_rm_last) begin
                            n_occ = r_occ - CW'(1);
                        end else begin
                            // close the gap from the removed slot upward
                            n_idx = r_pos;
                        end
                    end
                end
            end
            skct_pkg::S_INS_RD: begin
                w_raddr = w_idx_dn;
            end
            skct_pkg::S_INS_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_rd;
                n_idx   = w_idx_dn;
            end
            skct_pkg::S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = '{key: r_key, count: r_amt};
                n_occ   = r_occ + CW'(1);
            end
            skct_pkg::S_RM_RD: begin
                w_raddr = w_idx_up;
            end
            skct_pkg::S_RM_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_rd;
                n_idx   = w_idx_up;
                if (w_rm_done) begin
                    n_occ = r_occ - CW'(1);
                end
            end
            skct_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_taken = r_taken;
                    n_o_rem   = r_rem;
                    n_o_used  = skct_pkg::USED_W'(r_occ);
                    n_o_stat  = r_stat;
                end
            end
            default: begin
            end
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= skct_pkg::S_IDLE;
            r_occ     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_amt <= i_amount;
        end
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_found   <= n_found;
        r_have    <= n_have;
        r_taken   <= n_taken;
        r_rem     <= n_rem;
        r_stat    <= n_stat;
        r_o_taken <= n_o_taken;
        r_o_rem   <= n_o_rem;
        r_o_used  <= n_o_used;
        r_o_stat  <= n_o_stat;
    end

    assign o_valid        = r_o_valid;
    assign o_taken        = r_o_taken;
    assign o_remaining    = r_o_rem;
    assign o_entries_used = r_o_used;
    assign o_status       = r_o_stat;

endmodule

`default_nettype wire

// ===== sim/sorted_keyed_count_table_unit_test.sv =====
`default_nettype none

module sorted_keyed_count_table_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = skct_pkg::DEF_DEPTH;
    localparam int POOL_N      = 96;      // more keys than entries so the table can fill
    localparam int CALM_TAIL   = 150;     // last items run with no idling
    localparam int LONG_HOLD   = 500;     // receiver hold-off, in cycles
    localparam int HOLD_AFTER  = 250;     // results seen before the hold-off starts
    localparam int TAIL_CYCLES = 300;     // covers a full scan plus a full shift
    localparam int MAX_REPORTS = 10;

    // one input item plus a flag that makes the sender wait for an empty pipe
    typedef struct packed {
        logic                       cmd;
        logic [skct_pkg::KEY_W-1:0] key;
        logic [skct_pkg::CNT_W-1:0] amount;
        logic                       wait_idle;
    } t_table_op;

    typedef struct packed {
        logic [skct_pkg::CNT_W-1:0]  taken;
        logic [skct_pkg::CNT_W-1:0]  remaining;
        logic [skct_pkg::USED_W-1:0] used;
        logic [skct_pkg::STAT_W-1:0] status;
    } t_table_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic                        i_cmd = skct_pkg::CMD_STORE;
    logic [skct_pkg::KEY_W-1:0]  i_key = '0;
    logic [skct_pkg::CNT_W-1:0]  i_amount = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [skct_pkg::CNT_W-1:0]  o_taken;
    logic [skct_pkg::CNT_W-1:0]  o_remaining;
    logic [skct_pkg::USED_W-1:0] o_entries_used;
    logic [skct_pkg::STAT_W-1:0] o_status;

    sorted_keyed_count_table_unit #(.DEPTH(DEPTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_key          (i_key),
        .i_amount       (i_amount),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_taken        (o_taken),
        .o_remaining    (o_remaining),
        .o_entries_used (o_entries_used),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the table, kept sorted exactly like the block's memory
    logic [skct_pkg::KEY_W-1:0] shadow_key [DEPTH];
    logic [skct_pkg::CNT_W-1:0] shadow_cnt [DEPTH];
    int                         shadow_fill = 0;

    t_table_op                  pending_ops [$];
    t_table_result              expected_results [$];
    logic [skct_pkg::KEY_W-1:0] key_pool [POOL_N];

    int  fail_count     = 0;
    int  results_seen   = 0;
    bit  op_taken       = 1'b0;   // input transfer at the last rising edge
    int  send_gap       = 0;
    int  stall_left     = 0;
    bit  long_hold_done = 1'b0;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // apply one item to the shadow table and return what the block must answer
    function automatic t_table_result apply_table_op(
        input logic                       cmd,
        input logic [skct_pkg::KEY_W-1:0] key,
        input logic [skct_pkg::CNT_W-1:0] amount
    );
        t_table_result              r;
        int                         pos;
        int                         ins;
        int                         i;
        bit                         found;
        logic [skct_pkg::CNT_W:0]   sum;
        logic [skct_pkg::CNT_W-1:0] have;
        r = '0;
        r.status = skct_pkg::ST_OK;
        pos = shadow_fill;
        for (i = shadow_fill - 1; i >= 0; i--) begin
            if (shadow_key[i] == key) begin
                pos = i;
            end
        end
        found = (pos < shadow_fill);
        if (cmd == skct_pkg::CMD_STORE) begin
            if (found) begin
                sum = {1'b0, shadow_cnt[pos]} + {1'b0, amount};
                if (sum > {1'b0, skct_pkg::CNT_MAX}) begin
                    sum = {1'b0, skct_pkg::CNT_MAX};
                    r.status = skct_pkg::ST_SAT;
                end
                shadow_cnt[pos] = sum[skct_pkg::CNT_W-1:0];
                r.remaining = sum[skct_pkg::CNT_W-1:0];
            end else if (shadow_fill >= DEPTH) begin
                r.status = skct_pkg::ST_FULL;
            end else if (amount != '0) begin
                // zero amounts to absent keys never create an entry
                ins = 0;
                while (ins < shadow_fill && shadow_key[ins] < key) begin
                    ins++;
                end
                for (i = shadow_fill; i > ins; i--) begin
                    shadow_key[i] = shadow_key[i-1];
                    shadow_cnt[i] = shadow_cnt[i-1];
                end
                shadow_key[ins] = key;
                shadow_cnt[ins] = amount;
                shadow_fill++;
                r.remaining = amount;
            end
        end else begin
            if (!found) begin
                r.status = skct_pkg::ST_NOT_FOUND;
            end else begin
                have = shadow_cnt[pos];
                r.taken = (have < amount) ? have : amount;
                have = have - r.taken;
                shadow_cnt[pos] = have;
                r.remaining = have;
                if (have == '0) begin
                    // drained entry is removed, closing the gap
                    for (i = pos; i + 1 < shadow_fill; i++) begin
                        shadow_key[i] = shadow_key[i+1];
                        shadow_cnt[i] = shadow_cnt[i+1];
                    end
                    shadow_fill--;
                end
            end
        end
        r.used = skct_pkg::USED_W'(shadow_fill);
        return r;
    endfunction

    task automatic push_op(input logic cmd, input logic [skct_pkg::KEY_W-1:0] key,
                           input logic [skct_pkg::CNT_W-1:0] amount,
                           input logic wait_idle);
        t_table_op op;
        op.cmd       = cmd;
        op.key       = key;
        op.amount    = amount;
        op.wait_idle = wait_idle;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    // amounts mix zeros, near-max values for saturation, small values and full-range randoms
    function automatic logic [skct_pkg::CNT_W-1:0] pick_amount();
        case ($urandom_range(0, 9)) inside
            0:       return '0;
            1:       return skct_pkg::CNT_MAX;
            2:       return skct_pkg::CNT_W'($urandom_range(65000, 65535));
            [3:5]:   return skct_pkg::CNT_W'($urandom_range(1, 500));
            default: return skct_pkg::CNT_W'($urandom);
        endcase
    endfunction

    // mostly keys from the pool so items hit live entries, some pure noise
    task automatic queue_random_ops(input int count, input int store_pct,
                                    input int noise_pct);
        logic                       cmd;
        logic [skct_pkg::KEY_W-1:0] key;
        for (int n = 0; n < count; n++) begin
            cmd = ($urandom_range(0, 99) < store_pct) ? skct_pkg::CMD_STORE
                                                      : skct_pkg::CMD_CONSUME;
            if ($urandom_range(0, 99) < noise_pct) begin
                key = skct_pkg::KEY_W'($urandom);
            end else begin
                key = key_pool[$urandom_range(0, POOL_N - 1)];
            end
            push_op(cmd, key, pick_amount(), (n == 0));
        end
    endtask

    // result check first, then prediction for the item taken at this edge
    always @(posedge i_clk) begin
        t_table_result e;
        t_table_result a;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                a.taken     = o_taken;
                a.remaining = o_remaining;
                a.used      = o_entries_used;
                a.status    = o_status;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result: taken %0d remaining %0d used %0d status %0d",
                        a.taken, a.remaining, a.used, a.status));
                end else begin
                    e = expected_results.pop_front();
                    if (a.taken != e.taken || a.remaining != e.remaining ||
                        a.used != e.used || a.status != e.status) begin
                        note_failure({$sformatf("mismatch at result %0d (expected/actual): ",
                                                results_seen),
                                      $sformatf("taken %0d/%0d remaining %0d/%0d ",
                                                e.taken, a.taken, e.remaining, a.remaining),
                                      $sformatf("used %0d/%0d status %0d/%0d",
                                                e.used, a.used, e.status, a.status)});
                    end
                end
            end
            if (i_valid && o_ready) begin
                expected_results.insert(expected_results.size(),
                                        apply_table_op(i_cmd, i_key, i_amount));
            end
            op_taken = i_valid && o_ready;
        end else begin
            op_taken = 1'b0;
        end
    end

    // sender: holds an item until its transfer, then gaps or moves on
    always @(negedge i_clk) begin
        t_table_op op;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !op_taken) begin
            // offer still pending, keep payload steady
        end else if (send_gap > 0) begin
            i_valid <= 1'b0;
            send_gap--;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].wait_idle && expected_results.size() != 0)) begin
            op = pending_ops.pop_front();
            i_cmd    <= op.cmd;
            i_key    <= op.key;
            i_amount <= op.amount;
            i_valid  <= 1'b1;
            if (pending_ops.size() >= CALM_TAIL && $urandom_range(0, 3) == 0) begin
                send_gap = $urandom_range(1, 10);
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: random stall bursts plus one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            i_ready <= 1'b0;
        end else if (pending_ops.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        key_pool[0] = '0;
        key_pool[1] = {skct_pkg::KEY_W{1'b1}};
        for (int k = 2; k < POOL_N; k++) begin
            key_pool[k] = skct_pkg::KEY_W'($urandom);
        end

        // directed: edges of keys and amounts, and each corner case
        push_op(skct_pkg::CMD_CONSUME, 16'd0,    16'd5,    1'b0); // consume on empty table
        push_op(skct_pkg::CMD_STORE,   16'd100,  16'd0,    1'b0); // zero store, key absent
        push_op(skct_pkg::CMD_STORE,   16'd100,  16'd10,   1'b0);
        push_op(skct_pkg::CMD_STORE,   16'd0,    skct_pkg::CNT_MAX, 1'b0); // lowest key, max
        push_op(skct_pkg::CMD_STORE,   16'hFFFF, 16'd1,    1'b0); // highest key
        push_op(skct_pkg::CMD_STORE,   16'd100,  skct_pkg::CNT_MAX, 1'b0); // saturates
        push_op(skct_pkg::CMD_STORE,   16'd0,    16'd1,    1'b0); // saturates from max
        push_op(skct_pkg::CMD_STORE,   16'd100,  16'd0,    1'b0); // zero store, key present
        push_op(skct_pkg::CMD_CONSUME, 16'd100,  16'd0,    1'b0); // zero consume
        push_op(skct_pkg::CMD_CONSUME, 16'hFFFF, skct_pkg::CNT_MAX, 1'b0); // short take
        push_op(skct_pkg::CMD_CONSUME, 16'hFFFF, 16'd1,    1'b0); // gone now
        push_op(skct_pkg::CMD_CONSUME, 16'd0,    16'd1000, 1'b0); // partial take
        push_op(skct_pkg::CMD_STORE,   16'd50,   16'd7,    1'b0); // insert in the middle
        push_op(skct_pkg::CMD_STORE,   16'd75,   16'h5555, 1'b0);
        push_op(skct_pkg::CMD_STORE,   16'd25,   16'hAAAA, 1'b0); // insert before
        push_op(skct_pkg::CMD_CONSUME, 16'd50,   16'd7,    1'b0); // exact take, middle removal
        push_op(skct_pkg::CMD_CONSUME, 16'd0,    skct_pkg::CNT_MAX, 1'b0); // removes the head
        push_op(skct_pkg::CMD_CONSUME, 16'h8000, 16'h8000, 1'b0); // miss with high bits set
        push_op(skct_pkg::CMD_STORE,   16'h7FFF, 16'h7FFF, 1'b0);

        // random phases: fill past full, churn, drain, refill
        queue_random_ops(400, 85, 5);
        queue_random_ops(600, 50, 10);
        queue_random_ops(400, 20, 5);
        queue_random_ops(200, 60, 10);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
